### hdl/ip6rt_pkg.sv
// shared types and constants for the ipv6 rule table
`timescale 1ns / 1ps

package ip6rt_pkg;

  // request codes
  localparam logic [2:0] REQ_CHECK = 3'd0;
  localparam logic [2:0] REQ_SET   = 3'd1;
  localparam logic [2:0] REQ_TSET  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;

  localparam int unsigned USED_MAX = 31;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [1:0]  verdict_in;
    logic [31:0] duration;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] verdict_out;
    logic       accepted;
    logic [4:0] used_count;
  } rsp_t;

  // one stored table entry
  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [1:0]  verdict;
    logic [31:0] expiry;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

### hdl/ip6rt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ip6rt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ip6rt_ctrl.sv
// request sequencer for the ipv6 rule table
`timescale 1ns / 1ps

module ip6rt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ip6rt_pkg::status_t status,
  output ip6rt_pkg::cmd_t    cmd,
  output logic               busy
);

  ip6rt_pkg::state_t state;
  ip6rt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ip6rt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ip6rt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ip6rt_pkg::ST_SCAN;
        end
      end
      ip6rt_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ip6rt_pkg::ST_COMMIT;
        end
      end
      ip6rt_pkg::ST_COMMIT: begin
        state_next = ip6rt_pkg::ST_IDLE;
      end
      default: begin
        state_next = ip6rt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ip6rt_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ip6rt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ip6rt_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### hdl/ip6rt_dp.sv
// table datapath: entry ram, valid bits, scan, commit and result register
`timescale 1ns / 1ps

module ip6rt_dp #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ip6rt_pkg::req_t    req,
  input  ip6rt_pkg::cmd_t    cmd,
  output ip6rt_pkg::status_t status,
  output logic               done,
  output ip6rt_pkg::rsp_t    rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = CNT_W + 5;

  ip6rt_pkg::req_t   req_q;
  logic [31:0]       sum_q;
  logic [31:0]       tick_now;

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] valid_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;

  logic [CNT_W-1:0]    addr_cnt;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_idx;

  logic                match_found;
  logic [IDX_W-1:0]    match_idx;
  logic [1:0]          match_verdict;
  logic [31:0]         match_expiry;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  ip6rt_pkg::entry_t   rd_entry;
  ip6rt_pkg::entry_t   wr_entry;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;

  logic                cmp_en;
  logic                cmp_live;
  logic                key_eq;
  logic                ages_out;
  logic [EXT_W-1:0]    cnt_ext;
  ip6rt_pkg::rsp_t     rsp_next;

  ip6rt_ram #(
    .WIDTH ($bits(ip6rt_pkg::entry_t)),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (addr_cnt[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  assign status.scan_done = (addr_cnt == CNT_W'(CAPACITY));

  assign cmp_en   = cmd.scan && cmp_valid;
  assign cmp_live = valid[cmp_idx];
  assign key_eq   = (rd_entry.key_high == req_q.addr_high) &&
                    (rd_entry.key_low == req_q.addr_low);
  assign ages_out = cmp_en && (req_q.req_type == ip6rt_pkg::REQ_TICK) && cmp_live &&
                    (rd_entry.expiry != 32'd0) && (tick_now >= rd_entry.expiry);

  always_comb begin
    valid_next = valid;
    count_next = count;
    ram_we     = 1'b0;
    ram_waddr  = match_found ? match_idx : free_idx;
    wr_entry.key_high = req_q.addr_high;
    wr_entry.key_low  = req_q.addr_low;
    wr_entry.verdict  = req_q.verdict_in;
    if (req_q.req_type == ip6rt_pkg::REQ_TSET) begin
      wr_entry.expiry = sum_q;
    end else if (match_found) begin
      wr_entry.expiry = match_expiry;
    end else begin
      wr_entry.expiry = 32'd0;
    end
    rsp_next = '0;

    // expired entry freed during the tick sweep
    if (ages_out) begin
      valid_next[cmp_idx] = 1'b0;
      count_next          = count - CNT_W'(1);
    end

    if (cmd.commit) begin
      case (req_q.req_type)
        ip6rt_pkg::REQ_CHECK: begin
          rsp_next.hit         = match_found;
          rsp_next.verdict_out = match_found ? match_verdict : 2'd0;
        end
        ip6rt_pkg::REQ_SET, ip6rt_pkg::REQ_TSET: begin
          if (match_found) begin
            ram_we            = 1'b1;
            rsp_next.accepted = 1'b1;
          end else if (free_found) begin
            ram_we               = 1'b1;
            valid_next[free_idx] = 1'b1;
            count_next           = count + CNT_W'(1);
            rsp_next.accepted    = 1'b1;
          end
        end
        ip6rt_pkg::REQ_CLEAR: begin
          if (match_found) begin
            valid_next[match_idx] = 1'b0;
            count_next            = count - CNT_W'(1);
          end
        end
        default: begin
          rsp_next.hit = 1'b0;
        end
      endcase
    end

    cnt_ext = EXT_W'(count_next);
    if (cnt_ext > EXT_W'(ip6rt_pkg::USED_MAX)) begin
      rsp_next.used_count = 5'(ip6rt_pkg::USED_MAX);
    end else begin
      rsp_next.used_count = cnt_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now    <= 32'd0;
      valid       <= '0;
      count       <= '0;
      addr_cnt    <= '0;
      cmp_valid   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      done        <= 1'b0;
    end else begin
      valid <= valid_next;
      count <= count_next;
      done  <= cmd.commit;
      if (cmd.capture) begin
        addr_cnt    <= '0;
        cmp_valid   <= 1'b0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        if (req.req_type == ip6rt_pkg::REQ_TICK) begin
          tick_now <= tick_now + 32'd1;
        end
      end else if (cmd.scan) begin
        cmp_valid <= (addr_cnt != CNT_W'(CAPACITY));
        if (addr_cnt != CNT_W'(CAPACITY)) begin
          addr_cnt <= addr_cnt + CNT_W'(1);
        end
        if (cmp_en && cmp_live && key_eq && !match_found) begin
          match_found <= 1'b1;
        end
        if (cmp_en && !cmp_live && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
      sum_q <= tick_now + req.duration;
    end
    if (cmd.scan) begin
      cmp_idx <= addr_cnt[IDX_W-1:0];
    end
    if (cmp_en && cmp_live && key_eq && !match_found) begin
      match_idx     <= cmp_idx;
      match_verdict <= rd_entry.verdict;
      match_expiry  <= rd_entry.expiry;
    end
    if (cmp_en && !cmp_live && !free_found) begin
      free_idx <= cmp_idx;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid)))
    else $error("entry count differs from valid bits");

  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.commit))
    else $error("result strobe without a commit");

  a_write_has_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (cmd.commit && (match_found || free_found)))
    else $error("entry write without a matched or free slot");

  a_fill_grows_count: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !match_found) |=> (count == $past(count) + CNT_W'(1)))
    else $error("new entry did not raise the count");

endmodule

### hdl/ipv6_rule_table_timed_core.sv
// top level of the ipv6 rule table with entry ageing
`timescale 1ns / 1ps

// ipv6 rule table with entry ageing. up to CAPACITY 128-bit addresses are
// held, each with a 2-bit verdict and a 32-bit expiry tick (0 = never
// expires); the block keeps its own 32-bit tick counter. a request is
// taken when start is high and busy is low, and exactly one result comes
// back on rsp, shown for a single cycle with done high; the receiver has
// no way to hold it off, so it must take every transfer as it comes.
// a request runs through the scan and commit states before its result
// strobe rises, and only then can the next request be taken, whatever its
// kind: the entry store is one ram with a single registered read port,
// and the sweep reads one entry per cycle to find a match, the first free
// slot, or entries that have aged out, then moves on to the commit state.
// busy drops on the cycle that the result is shown, so the next request
// may be transferred while done is high. valid bits sit in flip-flops
// cleared by reset, so no clearing pass is needed after reset.
// used_count saturates at 31 for capacities above that.

module ipv6_rule_table_timed_core #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ip6rt_pkg::req_t req,
  output logic            done,
  output ip6rt_pkg::rsp_t rsp
);

  // control handshake between sequencer and datapath
  ip6rt_pkg::cmd_t    cmd;
  ip6rt_pkg::status_t status;

  ip6rt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // entry store, sweep logic and result register
  ip6rt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .rsp    (rsp)
  );

endmodule

### dv/ipv6_rule_table_timed_core_tb.sv
// self-checking testbench for the ipv6 rule table with entry ageing
`timescale 1ns / 1ps

module ipv6_rule_table_timed_core_tb;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned POOL_SIZE      = 24;    // more addresses than slots, so the table fills
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transfer of either kind

  // request codes 5 to 7 are not defined and must leave the table alone
  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  // request mix per random phase, in percent: check, set, timed set, clear, tick, undefined
  localparam logic [2:0] KIND_CODE [6] = '{ip6rt_pkg::REQ_CHECK, ip6rt_pkg::REQ_SET,
                                          ip6rt_pkg::REQ_TSET, ip6rt_pkg::REQ_CLEAR,
                                          ip6rt_pkg::REQ_TICK, REQ_RSVD_FIRST};
  localparam int unsigned MIX [4][6] = '{
    '{25, 40, 20,  5,  7, 3},   // filling
    '{25, 10, 30, 10, 22, 3},   // ageing
    '{30, 20, 15, 20, 12, 3},   // churn
    '{30, 20, 15, 20, 12, 3}    // churn, back to back
  };

  typedef struct {
    ip6rt_pkg::req_t item;
    bit              pinned;
    ip6rt_pkg::rsp_t want;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic            busy;
  ip6rt_pkg::req_t req;
  logic            done;
  ip6rt_pkg::rsp_t rsp;

  // a directed row may carry its expected result, sent along with the request
  bit              req_pinned;
  ip6rt_pkg::rsp_t pinned_rsp;

  // shadow of the table as the predictor sees it
  logic [63:0] tbl_key_hi [TABLE_DEPTH];
  logic [63:0] tbl_key_lo [TABLE_DEPTH];
  logic [1:0]  tbl_verdict [TABLE_DEPTH];
  logic [31:0] tbl_expiry [TABLE_DEPTH];
  bit          tbl_valid [TABLE_DEPTH];
  logic [31:0] tick_count;

  ip6rt_pkg::rsp_t table_rsp_q [$];
  stim_row_t       dir_rows [$];
  logic [63:0]     pool_hi [POOL_SIZE];
  logic [63:0]     pool_lo [POOL_SIZE];
  logic [31:0]     ticks_sent;       // driver's own count, used to aim timed sets at a wrap to zero
  int unsigned     error_count;
  int unsigned     stall_cycles;

  ipv6_rule_table_timed_core #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int shadow_slot(logic [63:0] hi, logic [63:0] lo);
    int slot;
    slot = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_key_hi[i] == hi && tbl_key_lo[i] == lo) slot = i;
    return slot;
  endfunction

  // applies one request to the shadow table and returns the result it should give
  function automatic ip6rt_pkg::rsp_t predict_table(ip6rt_pkg::req_t r);
    ip6rt_pkg::rsp_t o;
    int              slot;
    int unsigned     n;
    o = '0;
    slot = -1;
    n = 0;
    case (r.req_type)
      ip6rt_pkg::REQ_CHECK: begin
        slot = shadow_slot(r.addr_high, r.addr_low);
        if (slot >= 0) begin
          o.hit = 1'b1;
          o.verdict_out = tbl_verdict[slot];
        end
      end
      ip6rt_pkg::REQ_SET, ip6rt_pkg::REQ_TSET: begin
        slot = shadow_slot(r.addr_high, r.addr_low);
        // no match: take the lowest free slot, new entries start untimed
        if (slot < 0) begin
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!tbl_valid[i]) slot = i;
          if (slot >= 0) begin
            tbl_key_hi[slot] = r.addr_high;
            tbl_key_lo[slot] = r.addr_low;
            tbl_expiry[slot] = '0;
            tbl_valid[slot]  = 1'b1;
          end
        end
        if (slot >= 0) begin
          tbl_verdict[slot] = r.verdict_in;
          // a sum that wraps to zero leaves the entry permanent
          if (r.req_type == ip6rt_pkg::REQ_TSET) tbl_expiry[slot] = tick_count + r.duration;
          o.accepted = 1'b1;
        end
      end
      ip6rt_pkg::REQ_CLEAR: begin
        slot = shadow_slot(r.addr_high, r.addr_low);
        if (slot >= 0) tbl_valid[slot] = 1'b0;
      end
      ip6rt_pkg::REQ_TICK: begin
        tick_count = tick_count + 32'd1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tbl_valid[i] && tbl_expiry[i] != '0 && tick_count >= tbl_expiry[i])
            tbl_valid[i] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_valid[i]) n++;
    if (n > ip6rt_pkg::USED_MAX) n = ip6rt_pkg::USED_MAX;
    o.used_count = 5'(n);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic ip6rt_pkg::req_t mk_req(logic [2:0] code, logic [63:0] hi,
                                             logic [63:0] lo, logic [1:0] v,
                                             logic [31:0] dur);
    ip6rt_pkg::req_t r;
    r.req_type   = code;
    r.addr_high  = hi;
    r.addr_low   = lo;
    r.verdict_in = v;
    r.duration   = dur;
    return r;
  endfunction

  function automatic ip6rt_pkg::rsp_t mk_rsp(logic h, logic [1:0] v, logic a,
                                             logic [4:0] cnt);
    ip6rt_pkg::rsp_t o;
    o.hit         = h;
    o.verdict_out = v;
    o.accepted    = a;
    o.used_count  = cnt;
    return o;
  endfunction

  task automatic add_row(input ip6rt_pkg::req_t r, input bit pin, input ip6rt_pkg::rsp_t w);
    stim_row_t row;
    row.item   = r;
    row.pinned = pin;
    row.want   = w;
    dir_rows.push_back(row);
  endtask

  // A is all ones, B all zeros, C shares A's upper half only
  task automatic build_directed();
    ip6rt_pkg::rsp_t none;
    none = '0;
    add_row(mk_req(ip6rt_pkg::REQ_CHECK, ALL_ONES, ALL_ONES, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd0));
    add_row(mk_req(REQ_RSVD_LAST, ALL_ONES, ALL_ONES, 2'd3, '1), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd0));
    add_row(mk_req(ip6rt_pkg::REQ_SET, ALL_ONES, ALL_ONES, 2'd3, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b1, 5'd1));
    add_row(mk_req(ip6rt_pkg::REQ_CHECK, ALL_ONES, ALL_ONES, 2'd0, '0), 1'b1,
            mk_rsp(1'b1, 2'd3, 1'b0, 5'd1));
    // one half matching is still a miss
    add_row(mk_req(ip6rt_pkg::REQ_CHECK, ALL_ONES, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd1));
    add_row(mk_req(ip6rt_pkg::REQ_SET, '0, '0, 2'd0, '1), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b1, 5'd2));
    // update in place, no new slot taken
    add_row(mk_req(ip6rt_pkg::REQ_SET, ALL_ONES, ALL_ONES, 2'd1, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b1, 5'd2));
    add_row(mk_req(ip6rt_pkg::REQ_TSET, ALL_ONES, '0, 2'd2, 32'd2), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b1, 5'd3));
    // plain set on a timed entry keeps its expiry
    add_row(mk_req(ip6rt_pkg::REQ_SET, ALL_ONES, '0, 2'd1, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b1, 5'd3));
    add_row(mk_req(ip6rt_pkg::REQ_TICK, '0, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd3));
    // tick 1 plus all ones wraps to zero: B becomes permanent
    add_row(mk_req(ip6rt_pkg::REQ_TSET, '0, '0, 2'd2, '1), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b1, 5'd3));
    add_row(mk_req(ip6rt_pkg::REQ_TICK, '0, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd2));
    add_row(mk_req(ip6rt_pkg::REQ_CHECK, ALL_ONES, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd2));
    // untimed entry turned timed by a timed set
    add_row(mk_req(ip6rt_pkg::REQ_TSET, ALL_ONES, ALL_ONES, 2'd1, 32'd1), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b1, 5'd2));
    add_row(mk_req(ip6rt_pkg::REQ_TICK, '0, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd1));
    add_row(mk_req(ip6rt_pkg::REQ_CHECK, '0, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b1, 2'd2, 1'b0, 5'd1));
    add_row(mk_req(ip6rt_pkg::REQ_CLEAR, ALL_ONES, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd1));
    add_row(mk_req(ip6rt_pkg::REQ_CLEAR, '0, '0, 2'd0, '0), 1'b1,
            mk_rsp(1'b0, 2'd0, 1'b0, 5'd0));
    // fill every slot, then two stores that must bounce off the full table
    for (int i = 0; i < TABLE_DEPTH; i++)
      add_row(mk_req(ip6rt_pkg::REQ_SET, pool_hi[i], pool_lo[i], 2'($urandom_range(0, 3)),
                     $urandom), 1'b0, none);
    add_row(mk_req(ip6rt_pkg::REQ_SET, pool_hi[TABLE_DEPTH], pool_lo[TABLE_DEPTH], 2'd3, '0),
            1'b1, mk_rsp(1'b0, 2'd0, 1'b0, 5'(TABLE_DEPTH)));
    add_row(mk_req(ip6rt_pkg::REQ_TSET, pool_hi[TABLE_DEPTH + 1], pool_lo[TABLE_DEPTH + 1],
                   2'd2, 32'd5),
            1'b1, mk_rsp(1'b0, 2'd0, 1'b0, 5'(TABLE_DEPTH)));
  endtask

  function automatic ip6rt_pkg::req_t random_req(int unsigned phase);
    ip6rt_pkg::req_t r;
    int unsigned     pick;
    int unsigned     sum_w;
    int unsigned     kind;
    int unsigned     slot;
    pick  = $urandom_range(0, 99);
    sum_w = 0;
    kind  = 5;
    for (int k = 5; k >= 0; k--) begin
      sum_w = 0;
      for (int j = 0; j <= k; j++) sum_w += MIX[phase][j];
      if (pick < sum_w) kind = k;
    end
    r.req_type = KIND_CODE[kind];
    if (r.req_type == REQ_RSVD_FIRST)
      r.req_type = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
    r.verdict_in = 2'($urandom_range(0, 3));
    r.duration   = $urandom;
    // stores always use the pool so that the table does not clog with
    // permanent one-off addresses; other kinds sometimes miss on purpose
    if (r.req_type == ip6rt_pkg::REQ_SET || r.req_type == ip6rt_pkg::REQ_TSET ||
        $urandom_range(0, 99) < 85) begin
      slot = $urandom_range(0, POOL_SIZE - 1);
      r.addr_high = pool_hi[slot];
      r.addr_low  = pool_lo[slot];
    end else begin
      r.addr_high = {$urandom, $urandom};
      r.addr_low  = {$urandom, $urandom};
    end
    if (r.req_type == ip6rt_pkg::REQ_TSET) begin
      case ($urandom_range(0, 9))
        6:       r.duration = '0;
        7:       r.duration = '0 - ticks_sent;   // lands exactly on zero
        8:       r.duration = '1;
        9:       r.duration = $urandom;
        default: r.duration = 32'($urandom_range(1, 8));
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------

  // holds the request up until the block takes it; returns on the accepting edge
  task automatic send_req(input ip6rt_pkg::req_t r, input bit pin,
                          input ip6rt_pkg::rsp_t want);
    start      <= 1'b1;
    req        <= r;
    req_pinned <= pin;
    pinned_rsp <= want;
    do @(posedge clk); while (busy);
    if (r.req_type == ip6rt_pkg::REQ_TICK) ticks_sent = ticks_sent + 32'd1;
  endtask

  // stop sending until every outstanding result is back; sampled on the
  // falling edge so the checker's updates at the rising edge have settled
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (table_rsp_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic check_rsp(input ip6rt_pkg::rsp_t want, input ip6rt_pkg::rsp_t got);
    if (got.hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, got.hit);
      error_count++;
    end
    if (got.verdict_out !== want.verdict_out) begin
      $error("verdict_out: expected %0d, got %0d", want.verdict_out, got.verdict_out);
      error_count++;
    end
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
      error_count++;
    end
    if (got.used_count !== want.used_count) begin
      $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor, checker and watchdog
  // ---------------------------------------------------------------------------

  // everything here samples values from before the edge, since all inputs and
  // outputs change through nonblocking updates
  always @(posedge clk) begin : monitor
    ip6rt_pkg::rsp_t want;
    if (!rst) begin
      // a result transfer is checked first; a request taken on the same edge
      // queues behind it
      if (done) begin
        if (table_rsp_q.size() == 0) begin
          $error("result with nothing outstanding: %p", rsp);
          error_count++;
        end else begin
          want = table_rsp_q.pop_front();
          check_rsp(want, rsp);
        end
      end
      if (start && !busy) begin
        want = predict_table(req);
        if (req_pinned) want = pinned_rsp;
        table_rsp_q.push_back(want);
      end
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("ipv6_rule_table_timed_core_tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned n;
    int unsigned burst;
    int unsigned phase;
    bit          paused_mid;
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    req_pinned   = 1'b0;
    pinned_rsp   = '0;
    tick_count   = '0;
    ticks_sent   = '0;
    error_count  = 0;
    stall_cycles = 0;
    n            = 0;
    paused_mid   = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;

    // pool addresses come in threes: a fresh one, one sharing its upper
    // half, one sharing the lower half of that, to catch half-key matches
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_hi[i] = (i % 3 == 1) ? pool_hi[i - 1] : {$urandom, $urandom};
      pool_lo[i] = (i % 3 == 2) ? pool_lo[i - 1] : {$urandom, $urandom};
    end
    build_directed();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rows back to back
    foreach (dir_rows[i]) send_req(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].want);
    wait_drained();

    // random part: bursts with gaps, the last quarter without gaps
    while (n < RANDOM_ITEMS) begin
      phase = (n * 4) / RANDOM_ITEMS;
      burst = (phase == 3) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
        send_req(random_req(phase), 1'b0, '0);
        n++;
      end
      if (!paused_mid && n >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused_mid = 1'b1;
      end else if (phase != 3) begin
        // gaps shorter and longer than one request's latency
        start <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 25)) @(posedge clk);
      end
    end

    wait_drained();
    // room for any stray result
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("ipv6_rule_table_timed_core_tb: done, clean");
    end else begin
      $display("ipv6_rule_table_timed_core_tb: done, errors");
    end
    $finish;
  end

endmodule
